@@ rtl/core/phf_pkg.sv @@
// Package: shared types and constants for pose_history_fusion.
package phf_pkg;

  localparam logic [16:0] GAIN_RESET = 17'd65857;
  localparam logic [16:0] KEEP_RESET = 17'd63570;
  localparam logic [16:0] KEEP_ONE   = 17'd65536;

  localparam logic [0:0] CFG_GAIN = 1'b0;
  localparam logic [0:0] CFG_KEEP = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_ALL_SEARCH  = 3'd2,
    ST_BEFORE_OLD  = 3'd3,
    ST_TOO_NEW     = 3'd4,
    ST_NO_NEXT     = 3'd5
  } status_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pa;
    logic        [31:0] stamp;
  } hist_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

@@ rtl/core/pose_history_fusion.sv @@
// Top level: fused planar pose estimator with a time-stamped history ring.
//
//  channel | ports                                  | timing
//  --------+----------------------------------------+---------------------------
//  input   | start, busy, in_*                      | transfer when start & !busy
//  result  | done, out_*                            | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_wdata           | write on cfg_we
//
// Odometry items pass through S_ODO, S_ODO2, S_WR and S_DONE; done is registered in
// S_DONE. Camera items take a read state, then S_WAIT and S_CMP per visited history
// entry (one history RAM read port, one compare), S_RDN, S_WAITN and S_LATN to fetch
// the next entry, a bit-serial divider (31-bit quotient), then 6 multiply/add pairs
// on one shared 33x33 multiplier. Reset is synchronous; the history RAM is not
// cleared, only head and wrap flag. The receiver cannot stall; busy is already low
// in the cycle that done is high.
module pose_history_fusion #(
  parameter int HISTORY_DEPTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_source,
  input  logic signed [31:0] in_delta_x,
  input  logic signed [31:0] in_delta_y,
  input  logic signed [31:0] in_delta_angle,
  input  logic        [31:0] in_record_time,
  input  logic        [31:0] in_vsync_time,
  output logic               done,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [31:0] out_pose_angle,
  output logic        [2:0]  out_search_status,
  output logic               out_moved,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [16:0] cfg_wdata
);
  import phf_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ODO   = 14'b00000000000010,
    S_ODO2  = 14'b00000000000100,
    S_RD    = 14'b00000000001000,
    S_WAIT  = 14'b00000000010000,
    S_CMP   = 14'b00000000100000,
    S_RDN   = 14'b00000001000000,
    S_WAITN = 14'b00000010000000,
    S_LATN  = 14'b00000100000000,
    S_DIV   = 14'b00001000000000,
    S_MUL   = 14'b00010000000000,
    S_ADD   = 14'b00100000000000,
    S_DONE  = 14'b01000000000000,
    S_WR    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [16:0] gain_r, keep_r;
  logic signed [31:0] fx_r, fy_r, fa_r;
  logic [AW-1:0] head_r;
  logic wrapped_r, moved_r;

  logic src_r;
  logic signed [31:0] cx_r, cy_r, ca_r;
  logic [31:0] rtime_r, vtime_r;

  hist_t mem [HISTORY_DEPTH];
  hist_t rd_r, e0_r, e1_r;
  logic [AW-1:0] rd_addr, it_r, start_r;
  logic [AW:0] steps_r;
  logic mem_we;
  hist_t wr_data;

  logic [2:0] status_r;

  // divider
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [30:0] quo_r;
  logic [5:0]  cnt_r;

  // shared multiplier
  logic [2:0] mi_r;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mp;
  logic signed [65:0] prod_r;
  logic signed [31:0] res_r [3];
  logic signed [31:0] interp_r [3];

  always_ff @(posedge clk) begin
    if (mem_we) mem[head_r] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    rd_addr = it_r;
    if (state_r == S_RDN || state_r == S_WAITN) rd_addr = (it_r == LAST) ? '0 : it_r + 1'b1;
  end

  // multiplier operand select: odometry by source, else 0..2 interp, 3..5 correction
  logic [16:0] comp;
  always_comb begin
    comp = KEEP_ONE - ((keep_r > KEEP_ONE) ? KEEP_ONE : keep_r);
    ma = '0;
    mb = '0;
    if (src_r == 1'b0) begin
      ma = {ca_r[31], ca_r};
      mb = {16'd0, gain_r};
    end else if (mi_r < 3'd3) begin
      case (mi_r)
        3'd0: ma = 33'(e1_r.px) - 33'(e0_r.px);
        3'd1: ma = 33'(e1_r.py) - 33'(e0_r.py);
        default: ma = 33'(e1_r.pa) - 33'(e0_r.pa);
      endcase
      mb = {2'b0, quo_r};
    end else begin
      case (mi_r)
        3'd3: ma = 33'(cx_r) - 33'(interp_r[0]);
        3'd4: ma = 33'(cy_r) - 33'(interp_r[1]);
        default: ma = 33'(ca_r) - 33'(interp_r[2]);
      endcase
      mb = {16'd0, comp};
    end
    mp = ma * mb;
  end

  logic signed [33:0] sum;
  logic signed [31:0] base;
  always_comb begin
    base = '0;
    sum = '0;
    if (src_r == 1'b0) begin
      sum = 34'(fa_r) + 34'(prod_r >>> 16);
    end else if (mi_r < 3'd4) begin
      case (mi_r)
        3'd1: base = e0_r.px;
        3'd2: base = e0_r.py;
        default: base = e0_r.pa;
      endcase
      sum = 34'(base) + 34'(prod_r >>> 30);
    end else begin
      case (mi_r)
        3'd4: base = fx_r;
        3'd5: base = fy_r;
        default: base = fa_r;
      endcase
      sum = 34'(base) + 34'(prod_r >>> 16);
    end
  end

  logic signed [31:0] nx_x, nx_y;
  assign nx_x = sat32(34'(fx_r) + 34'(cx_r));
  assign nx_y = sat32(34'(fy_r) + 34'(cy_r));
  assign wr_data = '{px: fx_r, py: fy_r, pa: fa_r, stamp: rtime_r};
  assign mem_we = (state_r == S_WR);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = in_source ? S_RD : S_ODO;
      S_ODO:   state_nxt = S_ODO2;
      S_ODO2:  state_nxt = S_WR;
      S_WR:    state_nxt = S_DONE;
      S_RD:    state_nxt = (head_r == '0 && !wrapped_r) ? S_DONE : S_WAIT;
      S_WAIT:  state_nxt = S_CMP;
      S_CMP:   state_nxt = S_CMP;
      S_RDN:   state_nxt = S_WAITN;
      S_WAITN: state_nxt = S_LATN;
      S_LATN:  state_nxt = S_DIV;
      S_DIV:   state_nxt = (cnt_r == '0) ? S_MUL : S_DIV;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = (mi_r == 3'd6) ? S_DONE : S_MUL;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_CMP) begin
      if (rd_r.stamp > vtime_r) begin
        if (it_r == head_r || steps_r > DEPTH_W) state_nxt = S_DONE;
        else if (it_r == '0 && !wrapped_r) state_nxt = S_DONE;
        else state_nxt = S_WAIT;
      end else if (it_r == start_r) begin
        state_nxt = S_DONE;
      end else if (((it_r == LAST) ? '0 : it_r + 1'b1) == head_r) begin
        state_nxt = S_DONE;
      end else begin
        state_nxt = S_RDN;
      end
    end
  end

  logic signed [31:0] nfx, nfy, nfa;
  assign nfx = fx_r;
  assign nfy = fy_r;
  assign nfa = fa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      gain_r    <= GAIN_RESET;
      keep_r    <= KEEP_RESET;
      fx_r      <= '0;
      fy_r      <= '0;
      fa_r      <= '0;
      head_r    <= '0;
      wrapped_r <= 1'b0;
      moved_r   <= 1'b0;
      done      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done    <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_GAIN) gain_r <= cfg_wdata;
        else keep_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            src_r   <= in_source;
            cx_r    <= in_delta_x;
            cy_r    <= in_delta_y;
            ca_r    <= in_delta_angle;
            rtime_r <= in_record_time;
            vtime_r <= in_vsync_time;
            status_r <= ST_OK;
            it_r    <= (head_r == '0) ? LAST : head_r - 1'b1;
            start_r <= (head_r == '0) ? LAST : head_r - 1'b1;
            steps_r <= '0;
            mi_r    <= '0;
          end
        end
        S_ODO: begin
          prod_r <= mp;
          fx_r   <= nx_x;
          fy_r   <= nx_y;
        end
        S_ODO2: fa_r <= sat32(sum);
        S_WR: begin
          head_r <= (head_r == LAST) ? '0 : head_r + 1'b1;
          if (head_r == LAST) wrapped_r <= 1'b1;
        end
        S_RD: if (head_r == '0 && !wrapped_r) status_r <= ST_EMPTY;
        S_CMP: begin
          if (rd_r.stamp > vtime_r) begin
            if (it_r == head_r || steps_r > DEPTH_W) status_r <= ST_ALL_SEARCH;
            else if (it_r == '0 && !wrapped_r) status_r <= ST_BEFORE_OLD;
            else begin
              it_r    <= (it_r == '0) ? LAST : it_r - 1'b1;
              steps_r <= steps_r + 1'b1;
            end
          end else if (it_r == start_r) begin
            status_r <= ST_TOO_NEW;
          end else if (((it_r == LAST) ? '0 : it_r + 1'b1) == head_r) begin
            status_r <= ST_NO_NEXT;
          end else begin
            e0_r <= rd_r;
          end
        end
        S_LATN: begin
          e1_r  <= rd_r;
          den_r <= rd_r.stamp - e0_r.stamp;
          rem_r <= {1'b0, vtime_r - e0_r.stamp};
          quo_r <= '0;
          cnt_r <= 6'd30;
        end
        S_DIV: begin
          if (den_r == '0) begin
            quo_r <= '0;
            cnt_r <= '0;
          end else begin
            if (rem_r >= {1'b0, den_r}) begin
              rem_r <= (rem_r - {1'b0, den_r}) << 1;
              quo_r <= {quo_r[29:0], 1'b1};
            end else begin
              rem_r <= rem_r << 1;
              quo_r <= {quo_r[29:0], 1'b0};
            end
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_MUL: begin
          prod_r <= mp;
          mi_r   <= mi_r + 1'b1;
        end
        S_ADD: begin
          case (mi_r)
            3'd1: interp_r[0] <= sat32(sum);
            3'd2: interp_r[1] <= sat32(sum);
            3'd3: interp_r[2] <= sat32(sum);
            3'd4: fx_r <= sat32(sum);
            3'd5: fy_r <= sat32(sum);
            default: fa_r <= sat32(sum);
          endcase
        end
        S_DONE: begin
          done <= 1'b1;
          if (nfx != 0 || nfy != 0 || nfa != 0) moved_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_pose_x        = fx_r;
  assign out_pose_y        = fy_r;
  assign out_pose_angle    = fa_r;
  assign out_search_status = status_r;
  assign out_moved         = moved_r;

endmodule

@@ rtl/core/phf_checker.sv @@
// Checker: port-level assertions for pose_history_fusion, bound to the top level.
module phf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        out_moved,
  input logic [2:0]  out_search_status
);
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after transfer");
  a_moved_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_moved) && $past(rst_n) |-> out_moved) else $error("moved cleared");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_search_status <= 3'd5) else $error("bad status");
endmodule

bind pose_history_fusion phf_checker u_phf_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
  .out_moved(out_moved), .out_search_status(out_search_status)
);
